@@ sv/drac_pkg.sv @@
// Shared types, constants and box helpers for the dirty region accumulator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package drac_pkg;

    localparam int COORD_BITS      = 16;
    localparam int DEF_NUM_SLOTS   = 16;
    localparam int CFG_W           = 5;
    localparam int SPAN_W          = COORD_BITS + 1;
    localparam int PROD_W          = 2 * SPAN_W;
    localparam int AREA_W          = 37;
    localparam int BAREA_W         = 33;
    localparam int OCNT_W          = 5;
    localparam int CMP_W           = 44;
    localparam int NUM_W           = 6;
    localparam int IN_TDATA_W      = 64;
    localparam int OUT_TDATA_W     = 144;
    localparam int KIND_W          = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord y2;
        t_coord x2;
        t_coord y1;
        t_coord x1;
    } t_box;

    typedef enum logic [KIND_W-1:0] {
        K_ADD   = 2'd0,
        K_CLEAR = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_ADD_END,
        S_SUM,
        S_SUM_END,
        S_CMP,
        S_PICK,
        S_EMIT,
        S_ONE
    } t_state;

    function automatic t_box f_union(input t_box a, input t_box b);
        t_box r;
        r    = a;
        if (b.x1 < a.x1) r.x1 = b.x1;
        if (b.y1 < a.y1) r.y1 = b.y1;
        if (b.x2 > a.x2) r.x2 = b.x2;
        if (b.y2 > a.y2) r.y2 = b.y2;
        return r;
    endfunction

    function automatic logic [SPAN_W-1:0] f_span(input t_coord lo, input t_coord hi);
        logic signed [SPAN_W-1:0] d;
        d = SPAN_W'(hi) - SPAN_W'(lo) + SPAN_W'(1);
        return unsigned'(d);
    endfunction

endpackage
`default_nettype wire

@@ sv/dirty_region_accumulator_core.sv @@
// Screen damage tracker: a ring of region cells plus a bounding box.
// For an add item the stored regions rotate once through the merge unit at the
// ring head, one cell a cycle, and the S_ADD_END state then settles the merge,
// the append or the collapse. A read item sums areas and picks the readout,
// then emits a region list or the bounding box alone, each item held while
// the output stalls; a read of an empty list goes straight to one empty item,
// and a reset item clears the list. Depends on drac_pkg, drac_cell and
// drac_merge.
`default_nettype none
module dirty_region_accumulator_core #(
    parameter int NUM_SLOTS = drac_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [drac_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // left, top, right, bottom
    input  wire logic [drac_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // kind
    input  wire logic [drac_pkg::KIND_W-1:0]        i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // rect_x, rect_y, rect_w, rect_h, rect_count, total_area, bounding_area, zero fill
    output logic [drac_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic                                    o_m_tlast
);
    import drac_pkg::*;

    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]    r_cnt;
    logic [SW-1:0]    r_step;
    t_box             r_bb, r_new;
    logic             r_done, r_app, r_empty, r_pv;
    logic [PROD_W-1:0] r_prod, r_bound;
    logic [AREA_W-1:0] r_total;
    logic [CMP_W-1:0]  r_lhs, r_rhs;

    logic              r_ov, r_olast;
    t_box              r_obox;
    logic [SPAN_W-1:0] r_ow, r_oh;
    logic [OCNT_W-1:0] r_ocnt;
    logic [AREA_W-1:0] r_otot;
    logic [BAREA_W-1:0] r_obnd;

    t_box cells [NUM_SLOTS];
    t_box head, head_in, mbox, in_box, bb_next;
    logic hit, idx_lt, idx_eq, append, step_end, s_acc, out_free, stall;
    logic c_shift, c_load0, c_out_ring, c_out_one;
    t_box load0_data;
    logic [7:0] lim8, cnt8, step8;
    logic [NUM_W-1:0] num;
    t_kind kind;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign kind        = t_kind'(i_s_tuser);
    assign head        = cells[0];
    assign out_free    = !r_ov || i_m_tready;

    always_comb begin
        in_box.x1 = t_coord'(i_s_tdata[15:0]);
        in_box.y1 = t_coord'(i_s_tdata[31:16]);
        in_box.x2 = t_coord'(i_s_tdata[47:32]);
        in_box.y2 = t_coord'(i_s_tdata[63:48]);
        if (in_box.x2 < in_box.x1) begin
            in_box.x1 = t_coord'(i_s_tdata[47:32]);
            in_box.x2 = t_coord'(i_s_tdata[15:0]);
        end
        if (in_box.y2 < in_box.y1) begin
            in_box.y1 = t_coord'(i_s_tdata[63:48]);
            in_box.y2 = t_coord'(i_s_tdata[31:16]);
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            lim8 = 8'd1;
        end else if (8'(r_cfg) > 8'(NUM_SLOTS)) begin
            lim8 = 8'(NUM_SLOTS);
        end else begin
            lim8 = 8'(r_cfg);
        end
        cnt8    = 8'(r_cnt);
        step8   = 8'(r_step);
        num     = (cnt8 <= lim8) ? NUM_W'(lim8 - cnt8 + 8'd1) : NUM_W'(1);
    end

    assign idx_lt   = step8 < cnt8;
    assign idx_eq   = step8 == cnt8;
    assign step_end = r_step == SW'(NUM_SLOTS - 1);
    assign append   = (r_state == S_ADD) && !r_done && idx_eq && (cnt8 < lim8);
    assign stall    = idx_lt && !out_free;
    assign bb_next  = f_union(r_bb, r_new);

    drac_merge u_merge (
        .i_check (r_state == S_ADD && idx_lt && !r_done),
        .i_head  (head),
        .i_new   (r_new),
        .o_hit   (hit),
        .o_box   (mbox)
    );

    assign head_in = hit ? mbox : (append ? r_new : head);

    genvar k;
    generate
        for (k = 0; k < NUM_SLOTS; k++) begin : g_cell
            t_box sd;
            if (k == NUM_SLOTS - 1) begin : g_tail
                assign sd = head_in;
            end else begin : g_mid
                assign sd = cells[k+1];
            end
            drac_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (c_shift),
                .i_load  ((k == 0) && c_load0),
                .i_sdata (sd),
                .i_ldata (load0_data),
                .o_q     (cells[k])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && kind == K_ADD && r_cnt != '0) begin
                    n_state = S_ADD;
                end else if (s_acc && kind == K_READ) begin
                    n_state = (r_cnt == '0) ? S_ONE : S_SUM;
                end
            end
            S_ADD:     if (step_end) n_state = S_ADD_END;
            S_ADD_END: n_state = S_IDLE;
            S_SUM:     if (step_end) n_state = S_SUM_END;
            S_SUM_END: n_state = S_CMP;
            S_CMP:     n_state = S_PICK;
            S_PICK:    n_state = ((cnt8 > 8'd1) && (r_lhs <= r_rhs)) ? S_EMIT : S_ONE;
            S_EMIT:    if (step_end && !stall) n_state = S_IDLE;
            S_ONE:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_shift    = 1'b0;
        c_load0    = 1'b0;
        c_out_ring = 1'b0;
        c_out_one  = 1'b0;
        load0_data = in_box;
        unique case (r_state)
            S_IDLE: c_load0 = s_acc && kind == K_ADD && r_cnt == '0;
            S_ADD, S_SUM: c_shift = 1'b1;
            S_ADD_END: begin
                c_load0    = !r_done && !r_app;
                load0_data = bb_next;
            end
            S_EMIT: begin
                c_shift    = !stall;
                c_out_ring = idx_lt && out_free;
            end
            S_ONE:   c_out_one = out_free;
            default: c_shift = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CFG_RESET;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            if (c_out_ring || c_out_one) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (s_acc && kind == K_CLEAR) r_cnt <= '0;
            if (c_load0 && r_state == S_IDLE) r_cnt <= CW'(1);
            if (r_state == S_ADD_END) begin
                if (r_app) begin
                    r_cnt <= r_cnt + CW'(1);
                end else if (!r_done) begin
                    r_cnt <= CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE || r_state == S_PICK) begin
            r_step <= '0;
        end else if (c_shift) begin
            r_step <= r_step + SW'(1);
        end
        case (r_state)
            S_IDLE: begin
                r_done  <= 1'b0;
                r_app   <= 1'b0;
                r_pv    <= 1'b0;
                r_total <= '0;
                r_new   <= in_box;
                r_empty <= (r_cnt == '0);
                if (c_load0) r_bb <= in_box;
            end
            S_ADD: begin
                if (hit || append) r_done <= 1'b1;
                if (append) r_app <= 1'b1;
            end
            S_ADD_END: r_bb <= bb_next;
            S_SUM: begin
                r_prod  <= PROD_W'(f_span(head.x1, head.x2)) * PROD_W'(f_span(head.y1, head.y2));
                r_pv    <= idx_lt;
                r_total <= r_total + (r_pv ? AREA_W'(r_prod) : '0);
            end
            S_SUM_END: begin
                r_total <= r_total + (r_pv ? AREA_W'(r_prod) : '0);
                r_bound <= PROD_W'(f_span(r_bb.x1, r_bb.x2)) * PROD_W'(f_span(r_bb.y1, r_bb.y2));
            end
            S_CMP: begin
                r_lhs <= (CMP_W'(r_total) + CMP_W'(1)) * CMP_W'(num + NUM_W'(1));
                r_rhs <= CMP_W'(r_bound) * CMP_W'(num);
            end
            default: ;
        endcase
        if (c_out_ring) begin
            r_obox  <= head;
            r_ow    <= f_span(head.x1, head.x2);
            r_oh    <= f_span(head.y1, head.y2);
            r_ocnt  <= cnt8[OCNT_W-1:0];
            r_olast <= step8 == cnt8 - 8'd1;
            r_otot  <= r_total;
            r_obnd  <= BAREA_W'(r_bound);
        end else if (c_out_one) begin
            r_olast <= 1'b1;
            if (r_empty) begin
                r_obox  <= '0;
                r_ow    <= '0;
                r_oh    <= '0;
                r_ocnt  <= '0;
                r_otot  <= '0;
                r_obnd  <= '0;
            end else begin
                r_obox <= r_bb;
                r_ow   <= f_span(r_bb.x1, r_bb.x2);
                r_oh   <= f_span(r_bb.y1, r_bb.y2);
                r_ocnt <= OCNT_W'(1);
                r_otot <= r_total;
                r_obnd <= BAREA_W'(r_bound);
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {3'b000, r_obnd, r_otot, r_ocnt, r_oh, r_ow,
                         r_obox.y1, r_obox.x1};

endmodule
`default_nettype wire

@@ sv/drac_cell.sv @@
// One storage cell of the region ring: holds one region and passes it on.
// Depends on drac_pkg for the region type.
`default_nettype none
module drac_cell (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire logic          i_load,
    input  wire drac_pkg::t_box i_sdata,
    input  wire drac_pkg::t_box i_ldata,
    output drac_pkg::t_box      o_q
);
    import drac_pkg::*;

    t_box r_box;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_box <= i_ldata;
        end else if (i_shift) begin
            r_box <= i_sdata;
        end
    end

    assign o_q = r_box;

endmodule
`default_nettype wire

@@ sv/drac_merge.sv @@
// Touch test and union of the ring head region with the incoming region.
// Depends on drac_pkg for the region type and the union helper.
`default_nettype none
module drac_merge (
    input  wire logic           i_check,
    input  wire drac_pkg::t_box i_head,
    input  wire drac_pkg::t_box i_new,
    output logic                o_hit,
    output drac_pkg::t_box      o_box
);
    import drac_pkg::*;

    logic signed [COORD_BITS:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic overlap, vert, horz;

    always_comb begin
        ax1 = (COORD_BITS+1)'(i_head.x1);
        ay1 = (COORD_BITS+1)'(i_head.y1);
        ax2 = (COORD_BITS+1)'(i_head.x2);
        ay2 = (COORD_BITS+1)'(i_head.y2);
        bx1 = (COORD_BITS+1)'(i_new.x1);
        by1 = (COORD_BITS+1)'(i_new.y1);
        bx2 = (COORD_BITS+1)'(i_new.x2);
        by2 = (COORD_BITS+1)'(i_new.y2);
        overlap = (ax1 <= bx2) && (bx1 <= ax2) && (ay1 <= by2) && (by1 <= ay2);
        vert = (ax1 == bx1) && (ax2 == bx2) &&
               ((ay2 + (COORD_BITS+1)'(1) == by1) || (by2 + (COORD_BITS+1)'(1) == ay1));
        horz = (ay1 == by1) && (ay2 == by2) &&
               ((ax2 + (COORD_BITS+1)'(1) == bx1) || (bx2 + (COORD_BITS+1)'(1) == ax1));
        o_hit = i_check && (overlap || vert || horz);
        o_box = f_union(i_head, i_new);
    end

endmodule
`default_nettype wire

@@ sv/drac_checker.sv @@
// Port-level checks for the dirty region accumulator, bound to the top level.
// Depends on drac_pkg for widths and on dirty_region_accumulator_core.
`default_nettype none
module drac_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_s_tvalid,
    input wire logic                               o_s_tready,
    input wire logic [drac_pkg::KIND_W-1:0]        i_s_tuser,
    input wire logic                               o_m_tvalid,
    input wire logic                               i_m_tready,
    input wire logic [drac_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input wire logic                               o_m_tlast
);
    import drac_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Output item changed while stalled.");

    a_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[70:66] > 5'd1)
        else $error("Non-final item in a readout of fewer than two.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[70:66] == 5'd0 |-> o_m_tlast && o_m_tdata[48:32] == '0)
        else $error("Empty readout item is malformed.");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser != K_READ && !o_m_tvalid |=> !o_m_tvalid)
        else $error("Output item without a read.");

endmodule

bind dirty_region_accumulator_core drac_checker u_drac_checker (.*);
`default_nettype wire
